FILE: rtl/slps_pkg.sv
// ----------------------------------------------------------------------------
// slps_pkg
// Shared types, codes and pattern tables of the status LED pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package slps_pkg;

   // Operation codes carried in the opcode field.
   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_SET_MODE = 1'b1;

   // Mode codes, shared by new_mode, mode_now and the mode register.
   localparam logic [2:0] MODE_OFF        = 3'd0;
   localparam logic [2:0] MODE_PORTAL     = 3'd1;
   localparam logic [2:0] MODE_CONNECTING = 3'd2;
   localparam logic [2:0] MODE_SUCCESS    = 3'd3;
   localparam logic [2:0] MODE_ERROR      = 3'd4;

   // Frame count of the six step patterns.
   localparam logic [2:0] SIX_STEP_LAST = 3'd5;
   localparam logic [2:0] SIX_STEPS     = 3'd6;

   typedef struct packed {
      logic       opcode;
      logic [2:0] new_mode;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [9:0] target_pixel;
      logic [2:0] mode_now;
   } rsp_type;

   // Sequencer state that lives between transactions.
   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] frame_step;
      logic [7:0] tick_count;
      logic       running;
   } seq_state_type;

   function automatic logic [7:0] mode_period(input logic [2:0] mode);
      logic [7:0] p;
      case (mode)
         MODE_PORTAL:     p = 8'd150;
         MODE_CONNECTING: p = 8'd80;
         MODE_SUCCESS:    p = 8'd120;
         MODE_ERROR:      p = 8'd180;
         default:         p = 8'd0;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] portal_level(input logic [1:0] s);
      logic [7:0] v;
      case (s)
         2'd0:    v = 8'd10;
         2'd1:    v = 8'd64;
         2'd2:    v = 8'd150;
         default: v = 8'd64;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] connect_level(input logic [1:0] s);
      return s[0] ? 8'd120 : 8'd0;
   endfunction

   function automatic logic [7:0] success_level(input logic [2:0] s);
      logic [7:0] v;
      case (s)
         3'd0:    v = 8'd120;
         3'd2:    v = 8'd120;
         3'd4:    v = 8'd180;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] error_level(input logic [2:0] s);
      logic [7:0] v;
      case (s)
         3'd0:    v = 8'd220;
         3'd2:    v = 8'd220;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/status_led_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer
// Drives one RGB status pixel through off, portal, connecting, success and
// error light patterns from millisecond ticks and mode commands.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle on the req_ channel, either
// a one-millisecond tick or a set-mode command, and returns zero or one color
// transaction on the rsp_ channel for each. A request first lands in an input
// register; once the result register is free or is being emptied, the step
// logic reads it together with the sequencer state, updates the state and,
// when there is a color to show, loads the result register. The sustained
// rate is one transaction per cycle as long as rsp_ready is high. When the
// response side stalls, the input register holds one more request before
// req_ready drops. The pixel index written through csr_wr_en/csr_wr_data is
// copied into every response; change it only while no transaction is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_pattern_sequencer (
   input  wire                    clock,
   input  wire                    reset,
   // Request channel.
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire slps_pkg::req_type req_payload,
   // Response channel.
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output slps_pkg::rsp_type      rsp_payload,
   // Configuration write port.
   input  wire                    csr_wr_en,
   input  wire logic [9:0]        csr_wr_data
);

   // Input register.
   logic              in_valid_ff;
   logic              in_valid_in;
   slps_pkg::req_type in_data_ff;

   // Sequencer state and configuration.
   slps_pkg::seq_state_type state_ff;
   slps_pkg::seq_state_type state_in;
   logic [9:0]              pixel_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   slps_pkg::rsp_type rsp_data_ff;

   logic              step_emit;
   slps_pkg::rsp_type step_rsp;
   logic              fire;
   logic              req_accept;

   slps_step u_step (
      .state_cur   (state_ff),
      .req         (in_data_ff),
      .pixel_index (pixel_ff),
      .state_next  (state_in),
      .emit        (step_emit),
      .rsp         (step_rsp)
   );

   // The held request is processed once the result register is free or
   // is being emptied in this same cycle.
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || fire;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      if (fire) begin
         rsp_valid_in = step_emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         pixel_ff     <= 10'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            pixel_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_payload;
      end
      if (fire && step_emit) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/slps_step.sv
// ----------------------------------------------------------------------------
// slps_step
// Next-state and result logic for one transaction: a tick or a mode command.
// ----------------------------------------------------------------------------
`default_nettype none

module slps_step (
   input  wire slps_pkg::seq_state_type state_cur,
   input  wire slps_pkg::req_type       req,
   input  wire logic [9:0]              pixel_index,
   output slps_pkg::seq_state_type      state_next,
   output logic                         emit,
   output slps_pkg::rsp_type            rsp
);

   logic [2:0] cmd_mode;
   logic [7:0] count_inc;
   logic [2:0] err_step;
   logic [1:0] ring_step;

   always_comb begin
      cmd_mode   = (req.new_mode > slps_pkg::MODE_ERROR) ? slps_pkg::MODE_OFF : req.new_mode;
      count_inc  = state_cur.tick_count + 8'd1;
      ring_step  = state_cur.frame_step[1:0];
      err_step   = (state_cur.frame_step >= slps_pkg::SIX_STEPS) ?
                   state_cur.frame_step - slps_pkg::SIX_STEPS : state_cur.frame_step;

      state_next       = state_cur;
      emit             = 1'b0;
      rsp.red          = 8'd0;
      rsp.green        = 8'd0;
      rsp.blue         = 8'd0;
      rsp.target_pixel = pixel_index;
      rsp.mode_now     = state_cur.mode;

      if (req.opcode == slps_pkg::OP_SET_MODE) begin
         // A repeat of the current mode is dropped; success always restarts.
         if (!(cmd_mode == state_cur.mode && cmd_mode != slps_pkg::MODE_SUCCESS)) begin
            state_next.mode       = cmd_mode;
            state_next.frame_step = 3'd0;
            state_next.tick_count = 8'd0;
            state_next.running    = (cmd_mode != slps_pkg::MODE_OFF);
            emit                  = 1'b1;
            rsp.mode_now          = cmd_mode;
            case (cmd_mode)
               slps_pkg::MODE_PORTAL:     rsp.blue = 8'd16;
               slps_pkg::MODE_CONNECTING: rsp.blue = 8'd120;
               slps_pkg::MODE_ERROR:      rsp.red  = 8'd64;
               default:                   ;
            endcase
         end
      end else if (state_cur.running) begin
         if (count_inc < slps_pkg::mode_period(state_cur.mode)) begin
            state_next.tick_count = count_inc;
         end else begin
            state_next.tick_count = 8'd0;
            case (state_cur.mode)
               slps_pkg::MODE_PORTAL: begin
                  state_next.frame_step = {1'b0, ring_step + 2'd1};
                  rsp.blue              = slps_pkg::portal_level(ring_step);
                  emit                  = 1'b1;
               end
               slps_pkg::MODE_CONNECTING: begin
                  state_next.frame_step = {1'b0, ring_step + 2'd1};
                  rsp.blue              = slps_pkg::connect_level(ring_step);
                  emit                  = 1'b1;
               end
               slps_pkg::MODE_SUCCESS: begin
                  if (state_cur.frame_step < slps_pkg::SIX_STEPS) begin
                     state_next.frame_step = state_cur.frame_step + 3'd1;
                     rsp.green = slps_pkg::success_level(state_cur.frame_step);
                     emit      = 1'b1;
                     // The last step already reports the drop back to off.
                     if (state_cur.frame_step == slps_pkg::SIX_STEP_LAST) begin
                        state_next.running = 1'b0;
                        state_next.mode    = slps_pkg::MODE_OFF;
                        rsp.mode_now       = slps_pkg::MODE_OFF;
                     end
                  end
               end
               slps_pkg::MODE_ERROR: begin
                  state_next.frame_step = (err_step == slps_pkg::SIX_STEP_LAST) ?
                                          3'd0 : err_step + 3'd1;
                  rsp.red               = slps_pkg::error_level(err_step);
                  emit                  = 1'b1;
               end
               default: begin
                  state_next.running = 1'b0;
                  emit               = 1'b1;
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/slps_checker.sv
// ----------------------------------------------------------------------------
// slps_checker
// Port-level assertions for the status LED pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module slps_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_ready,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wire slps_pkg::rsp_type rsp_payload
);

   // No response can be pending in the cycle after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Every pattern lights at most one color channel.
   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_payload.red != 8'd0, rsp_payload.green != 8'd0,
                                rsp_payload.blue != 8'd0}) <= 1)
      else $error("more than one color channel lit");

   // Reported modes stay within the five known modes.
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.mode_now <= slps_pkg::MODE_ERROR)
      else $error("unknown mode reported");

   // With an idle response side the input register drains, so ready returns.
   a_ready_returns: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && rsp_ready |-> req_ready)
      else $error("request side stalled with free result register");

endmodule

bind status_led_pattern_sequencer slps_checker u_slps_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
